@@ hdl/cfl_pkg.sv @@
// shared types, constants and helpers for the courant timestep reduction
package cfl_pkg;

    localparam int FRAC_BITS = 16;
    localparam int WORD_W = 32;

    // dividend must hold gamma * pressure and a speed shifted by the fraction
    localparam int GP_W = 19 + WORD_W;
    localparam int SPD_W = WORD_W + 1;
    localparam int DIV_W = (GP_W > SPD_W + FRAC_BITS) ? GP_W : SPD_W + FRAC_BITS;
    localparam int DIV_CW = $clog2(DIV_W + 1);

    // integer square root works on an even number of bits
    localparam int SQ_IN_W = WORD_W + FRAC_BITS;
    localparam int SQ_W = ((SQ_IN_W + 1) / 2) * 2;
    localparam int SQ_STEPS = SQ_W / 2;

    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);

    localparam logic [WORD_W-1:0] SAT_WORD = '1;

    localparam int CFG_AW = 3;
    typedef enum logic [CFG_AW-1:0] {
        REG_DIMS     = 3'd0,
        REG_GEOM_Y   = 3'd1,
        REG_GEOM_Z   = 3'd2,
        REG_GAMMA    = 3'd3,
        REG_COURANT  = 3'd4,
        REG_TIME_NOW = 3'd5
    } reg_idx_t;

    localparam logic [2:0] GEOM_CURV_MAX = 3'd2;
    localparam logic [2:0] GEOM_SPHERE = 3'd5;
    localparam logic [1:0] DIMS_ONE = 2'd1;
    localparam logic [1:0] DIMS_TWO = 2'd2;
    localparam logic [1:0] DIMS_THREE = 2'd3;

    localparam logic [WORD_W-1:0] DIMS_RST = 32'd1;
    localparam logic [WORD_W-1:0] GAMMA_RST = 32'd109227;
    localparam logic [WORD_W-1:0] COURANT_RST = 32'd16384;

    typedef struct packed {
        logic [1:0]  dims;
        logic [2:0]  geom_y;
        logic [2:0]  geom_z;
        logic [18:0] gamma;
        logic [16:0] courant;
        logic [31:0] time_now;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        pressure;
        logic [31:0]        density;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] vel_z;
        logic [31:0]        width_x;
        logic [31:0]        width_y;
        logic [31:0]        width_z;
        logic [31:0]        radius_center;
        logic [16:0]        sin_polar;
        logic               last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] timestep;
        logic [31:0] max_rate;
        logic        too_small;
    } out_item_t;

    // classified cell: payload plus what the back end has to do with it
    typedef struct packed {
        in_item_t   item;
        logic [1:0] n_dims;
        logic       scale_y_rad;
        logic       scale_z_rad;
        logic       scale_z_sin;
    } cmd_t;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [WORD_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quot;
    } div_rsp_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_MULG,
        B_DIVQ_GO,
        B_DIVQ_WAIT,
        B_SQRT,
        B_DIM,
        B_SCALE_RAD,
        B_SCALE_SIN,
        B_RATE_GO,
        B_RATE_WAIT,
        B_TS_GO,
        B_TS_WAIT,
        B_OUT
    } back_state_t;

    // (a * b) >> FRAC_BITS saturated to a word
    function automatic logic [WORD_W-1:0] mulq_sat(input logic [2*WORD_W-1:0] prod);
        logic [2*WORD_W-FRAC_BITS-1:0] sh;
        sh = prod[2*WORD_W-1:FRAC_BITS];
        if (sh[2*WORD_W-FRAC_BITS-1:WORD_W] != '0)
            return SAT_WORD;
        return sh[WORD_W-1:0];
    endfunction

    function automatic logic [SPD_W-1:0] abs_vel(input logic signed [31:0] v);
        if (v[31])
            return SPD_W'(33'h1_0000_0000 - {1'b0, v});
        return {1'b0, v};
    endfunction

endpackage

@@ hdl/cfl_fifo.sv @@
// short command queue between the front and back ends
module cfl_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  cfl_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output cfl_pkg::cmd_t rd_data,
    output logic          empty
);
    import cfl_pkg::*;

    cmd_t mem_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign full = (count_reg == FIFO_CW'(FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

@@ hdl/cfl_front.sv @@
// front end: takes cells and tags them with the work for each dimension
module cfl_front (
    input  logic              clk,
    input  logic              rst_n,
    input  cfl_pkg::cfg_t     cfg,
    input  logic              push,
    input  cfl_pkg::in_item_t in_item,
    output logic              full,
    output logic              cmd_valid,
    output cfl_pkg::cmd_t     cmd,
    input  logic              cmd_full
);
    import cfl_pkg::*;

    logic valid_reg, valid_next;
    cmd_t cmd_reg, cmd_next;
    logic take;
    logic [1:0] nd;

    assign full = valid_reg && cmd_full;
    assign take = push && !full;
    assign cmd_valid = valid_reg;
    assign cmd = cmd_reg;

    always_comb
    begin
        case (cfg.dims)
            DIMS_ONE: nd = DIMS_ONE;
            DIMS_TWO: nd = DIMS_TWO;
            default:  nd = DIMS_THREE;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        cmd_next = cmd_reg;
        if (valid_reg && !cmd_full)
        begin
            valid_next = 1'b0;
        end
        if (take)
        begin
            valid_next = 1'b1;
            cmd_next.item = in_item;
            cmd_next.n_dims = nd;
            cmd_next.scale_y_rad = (cfg.geom_y > GEOM_CURV_MAX);
            cmd_next.scale_z_rad = (cfg.geom_z > GEOM_CURV_MAX);
            cmd_next.scale_z_sin = (cfg.geom_z == GEOM_SPHERE);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
    end

endmodule

@@ hdl/cfl_div.sv @@
// restoring divider, one quotient bit per cycle, saturated word result
module cfl_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cfl_pkg::div_req_t req,
    output cfl_pkg::div_rsp_t rsp
);
    import cfl_pkg::*;

    logic [WORD_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] dvd_reg, dvd_next;
    logic [WORD_W-1:0] dvs_reg, dvs_next;
    logic [DIV_CW-1:0] cnt_reg, cnt_next;
    logic done_reg, done_next;
    logic [WORD_W:0] trial;
    logic fits;

    assign trial = {rem_reg, dvd_reg[DIV_W-1]};
    assign fits = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        rem_next = rem_reg;
        dvd_next = dvd_reg;
        dvs_next = dvs_reg;
        cnt_next = cnt_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next = '0;
            dvd_next = req.dividend;
            dvs_next = req.divisor;
            cnt_next = DIV_CW'(DIV_W);
        end
        else if (cnt_reg != '0)
        begin
            // quotient bits shift in where the dividend shifts out
            rem_next = fits ? WORD_W'(trial - {1'b0, dvs_reg}) : trial[WORD_W-1:0];
            dvd_next = {dvd_reg[DIV_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            done_next = (cnt_reg == DIV_CW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = (dvd_reg[DIV_W-1:WORD_W] != '0) ? SAT_WORD : dvd_reg[WORD_W-1:0];

endmodule

@@ hdl/cfl_back.sv @@
// back end: sound speed, per-dimension rates, running maximum and timestep
module cfl_back (
    input  logic               clk,
    input  logic               rst_n,
    input  cfl_pkg::cfg_t      cfg,
    input  cfl_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output cfl_pkg::div_req_t  div_req,
    input  cfl_pkg::div_rsp_t  div_rsp,
    output logic               empty,
    input  logic               pop,
    output cfl_pkg::out_item_t out_item
);
    import cfl_pkg::*;

    back_state_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;
    logic [2*WORD_W-1:0] prod_reg, prod_next;
    logic [SQ_W-1:0] v_reg, v_next, res_reg, res_next, bit_reg, bit_next;
    logic [SQ_STEPS-1:0] c_reg, c_next;
    logic [1:0] dim_reg, dim_next;
    logic [WORD_W-1:0] w_reg, w_next;
    logic [SPD_W-1:0] spd_reg, spd_next;
    logic [WORD_W-1:0] max_reg, max_next;
    logic out_valid_reg, out_valid_next;
    out_item_t out_reg, out_next;

    logic [WORD_W-1:0] dim_w;
    logic signed [31:0] dim_vel;
    logic dim_rad, dim_sin;
    logic [SQ_W-1:0] sq_trial;
    logic [WORD_W-1:0] scaled;
    logic last_dim;
    logic [WORD_W-1:0] dens;

    assign empty = !out_valid_reg;
    assign out_item = out_reg;
    assign scaled = mulq_sat(prod_reg);
    assign sq_trial = res_reg + bit_reg;
    assign last_dim = ({1'b0, dim_reg} + 3'd1 == {1'b0, cmd_reg.n_dims});
    assign dens = (cmd_reg.item.density == '0) ? WORD_W'(1) : cmd_reg.item.density;

    always_comb
    begin
        case (dim_reg)
            2'd0:
            begin
                dim_w = cmd_reg.item.width_x;
                dim_vel = cmd_reg.item.vel_x;
                dim_rad = 1'b0;
                dim_sin = 1'b0;
            end
            2'd1:
            begin
                dim_w = cmd_reg.item.width_y;
                dim_vel = cmd_reg.item.vel_y;
                dim_rad = cmd_reg.scale_y_rad;
                dim_sin = 1'b0;
            end
            default:
            begin
                dim_w = cmd_reg.item.width_z;
                dim_vel = cmd_reg.item.vel_z;
                dim_rad = cmd_reg.scale_z_rad;
                dim_sin = cmd_reg.scale_z_sin;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        prod_next = prod_reg;
        v_next = v_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        c_next = c_reg;
        dim_next = dim_reg;
        w_next = w_reg;
        spd_next = spd_reg;
        max_next = max_reg;
        out_valid_next = out_valid_reg;
        out_next = out_reg;
        cmd_pop = 1'b0;
        div_req.start = 1'b0;
        div_req.dividend = DIV_W'(prod_reg[GP_W-1:0]);
        div_req.divisor = dens;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE:
            begin
                if (!cmd_empty)
                begin
                    cmd_pop = 1'b1;
                    cmd_next = cmd;
                    state_next = B_MULG;
                end
            end
            B_MULG:
            begin
                prod_next = 64'(cfg.gamma) * 64'(cmd_reg.item.pressure);
                state_next = B_DIVQ_GO;
            end
            B_DIVQ_GO:
            begin
                div_req.start = 1'b1;
                state_next = B_DIVQ_WAIT;
            end
            B_DIVQ_WAIT:
            begin
                if (div_rsp.done)
                begin
                    v_next = SQ_W'({div_rsp.quot, {FRAC_BITS{1'b0}}});
                    res_next = '0;
                    bit_next = SQ_W'(1) << (SQ_W - 2);
                    state_next = B_SQRT;
                end
            end
            B_SQRT:
            begin
                if (bit_reg == '0)
                begin
                    c_next = res_reg[SQ_STEPS-1:0];
                    dim_next = 2'd0;
                    state_next = B_DIM;
                end
                else
                begin
                    if (v_reg >= sq_trial)
                    begin
                        v_next = v_reg - sq_trial;
                        res_next = (res_reg >> 1) + bit_reg;
                    end
                    else
                    begin
                        res_next = res_reg >> 1;
                    end
                    bit_next = bit_reg >> 2;
                end
            end
            B_DIM:
            begin
                w_next = dim_w;
                spd_next = abs_vel(dim_vel) + SPD_W'(c_reg);
                if (dim_rad)
                begin
                    prod_next = 64'(dim_w) * 64'(cmd_reg.item.radius_center);
                    state_next = B_SCALE_RAD;
                end
                else if (dim_sin)
                begin
                    prod_next = 64'(dim_w) * 64'(cmd_reg.item.sin_polar);
                    state_next = B_SCALE_SIN;
                end
                else
                begin
                    state_next = B_RATE_GO;
                end
            end
            B_SCALE_RAD:
            begin
                w_next = scaled;
                if (dim_sin)
                begin
                    prod_next = 64'(scaled) * 64'(cmd_reg.item.sin_polar);
                    state_next = B_SCALE_SIN;
                end
                else
                begin
                    state_next = B_RATE_GO;
                end
            end
            B_SCALE_SIN:
            begin
                w_next = scaled;
                state_next = B_RATE_GO;
            end
            B_RATE_GO:
            begin
                div_req.start = 1'b1;
                div_req.dividend = DIV_W'({spd_reg, {FRAC_BITS{1'b0}}});
                div_req.divisor = w_reg;
                state_next = B_RATE_WAIT;
            end
            B_RATE_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quot > max_reg)
                    begin
                        max_next = div_rsp.quot;
                    end
                    if (!last_dim)
                    begin
                        dim_next = dim_reg + 2'd1;
                        state_next = B_DIM;
                    end
                    else if (cmd_reg.item.last)
                    begin
                        state_next = B_TS_GO;
                    end
                    else
                    begin
                        state_next = B_IDLE;
                    end
                end
            end
            B_TS_GO:
            begin
                div_req.start = 1'b1;
                div_req.dividend = DIV_W'({cfg.courant, {FRAC_BITS{1'b0}}});
                div_req.divisor = max_reg;
                state_next = B_TS_WAIT;
            end
            B_TS_WAIT:
            begin
                // timestep parks in w_reg until the result register is free
                if (div_rsp.done)
                begin
                    w_next = div_rsp.quot;
                    state_next = B_OUT;
                end
            end
            B_OUT:
            begin
                if (!out_valid_next)
                begin
                    out_next.timestep = w_reg;
                    out_next.max_rate = max_reg;
                    // any nonzero timestep times 1e10 exceeds a 32-bit time
                    out_next.too_small = (w_reg == '0) && (cfg.time_now != '0);
                    out_valid_next = 1'b1;
                    max_next = '0;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            max_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            max_reg <= max_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        prod_reg <= prod_next;
        v_reg <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        c_reg <= c_next;
        dim_reg <= dim_next;
        w_reg <= w_next;
        spd_reg <= spd_next;
        out_reg <= out_next;
    end

endmodule

@@ hdl/cfl_timestep_reduction.sv @@
// top level: config registers, front end, command queue, back end, divider
// work per cell: the sound speed divide and one rate divide per active dimension, all on
// one shared divider, plus the timestep divide on the last cell; cells pass through the
// front end register and the queue before they reach the back end
// throughput: one cell at a time in the back end, set by the shared bit-serial divider
// and the 24-step square root; the front end and queue take up to three cells ahead
// reset: asynchronous active low, clears running maximum, queue, result and registers
module cfl_timestep_reduction (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [cfl_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [31:0]                cfg_wdata,
    input  logic                       push,
    output logic                       full,
    input  cfl_pkg::in_item_t          in_item,
    output logic                       empty,
    input  logic                       pop,
    output cfl_pkg::out_item_t         out_item
);
    import cfl_pkg::*;

    cfg_t cfg_reg;
    logic fr_valid, q_full, q_empty, q_pop;
    cmd_t fr_cmd, q_cmd;
    div_req_t div_req;
    div_rsp_t div_rsp;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dims <= DIMS_RST[1:0];
            cfg_reg.geom_y <= '0;
            cfg_reg.geom_z <= '0;
            cfg_reg.gamma <= GAMMA_RST[18:0];
            cfg_reg.courant <= COURANT_RST[16:0];
            cfg_reg.time_now <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_DIMS:     cfg_reg.dims <= cfg_wdata[1:0];
                REG_GEOM_Y:   cfg_reg.geom_y <= cfg_wdata[2:0];
                REG_GEOM_Z:   cfg_reg.geom_z <= cfg_wdata[2:0];
                REG_GAMMA:    cfg_reg.gamma <= cfg_wdata[18:0];
                REG_COURANT:  cfg_reg.courant <= cfg_wdata[16:0];
                REG_TIME_NOW: cfg_reg.time_now <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    cfl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (push),
        .in_item  (in_item),
        .full     (full),
        .cmd_valid(fr_valid),
        .cmd      (fr_cmd),
        .cmd_full (q_full)
    );

    cfl_fifo u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (fr_valid),
        .wr_data(fr_cmd),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_data(q_cmd),
        .empty  (q_empty)
    );

    cfl_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    cfl_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .cmd      (q_cmd),
        .cmd_empty(q_empty),
        .cmd_pop  (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .empty    (empty),
        .pop      (pop),
        .out_item (out_item)
    );

endmodule
